// ----- hdl/sqd_pkg.sv -----
// Shared constants for the shortest-queue dispatcher: field widths, op and status codes.
package sqd_pkg;

	// Default sizing
	localparam int NUM_QUEUES_DEF  = 5;
	localparam int QUEUE_DEPTH_DEF = 16;

	// Port field widths
	localparam int OP_W     = 1;
	localparam int SEL_W    = 4;
	localparam int STATUS_W = 3;
	localparam int TICKET_W = 16;
	localparam int LEN_W    = 5;

	// Request codes
	localparam logic [OP_W-1:0] OP_TAKE  = 1'b0;
	localparam logic [OP_W-1:0] OP_SERVE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_ASSIGNED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SERVED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

endpackage

// ----- hdl/sqd_select.sv -----
// Shortest-queue pick: lowest index among the queues holding the fewest entries.
module sqd_select #(
	parameter int NUM_QUEUES = sqd_pkg::NUM_QUEUES_DEF,
	parameter int CW         = $clog2(sqd_pkg::QUEUE_DEPTH_DEF + 1),
	parameter int QW         = $clog2(sqd_pkg::NUM_QUEUES_DEF)
) (
	input  logic [CW-1:0] counts [NUM_QUEUES],
	output logic [QW-1:0] best
);

	logic [NUM_QUEUES-1:0] win;

	// Each queue wins if it is strictly below every lower index and not above any higher one.
	// All compares run in parallel; exactly one queue wins.
	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++) begin
			win[i] = 1'b1;
			for (int j = 0; j < NUM_QUEUES; j++) begin
				if (j < i && !(counts[i] < counts[j]))
					win[i] = 1'b0;
				if (j > i && counts[j] < counts[i])
					win[i] = 1'b0;
			end
		end
	end

	// One-hot to index
	always_comb begin
		best = '0;
		for (int i = 0; i < NUM_QUEUES; i++) begin
			if (win[i])
				best = best | QW'(i);
		end
	end

endmodule

// ----- hdl/sqd_store.sv -----
// Ticket storage: one write port, one read port with registered read data.
module sqd_store #(
	parameter int ENTRIES = sqd_pkg::NUM_QUEUES_DEF * sqd_pkg::QUEUE_DEPTH_DEF,
	parameter int AW      = $clog2(sqd_pkg::NUM_QUEUES_DEF * sqd_pkg::QUEUE_DEPTH_DEF)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [sqd_pkg::TICKET_W-1:0]  wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [sqd_pkg::TICKET_W-1:0]  rdata
);

	logic [sqd_pkg::TICKET_W-1:0] mem [ENTRIES];

	// Write and registered read; read data holds when not enabled
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ----- hdl/shortest_queue_dispatcher.sv -----
// Top level of the shortest-queue dispatcher: queue state, request decode and result register.
// A take request bumps the 16-bit ticket counter and places the new ticket in the queue with the
// fewest entries (lowest index on a tie); a serve request pops the head ticket of the selected
// queue. Each accepted request yields exactly one result, in the cycle after its transfer, and a new
// request can be taken every cycle while the result stage is free or draining: the pick, the count
// and pointer updates and the ticket store access all finish in the cycle of the transfer, and the
// store's registered read port delivers a served ticket straight into the result stage. The input
// side is ready whenever the result stage is empty or its result is being taken in the same cycle.
// The ticket store needs no clearing after reset, so requests are taken from the first cycle.
module shortest_queue_dispatcher #(
	parameter int NUM_QUEUES  = sqd_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sqd_pkg::OP_W-1:0]      op,
	input  logic [sqd_pkg::SEL_W-1:0]     queue_select,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sqd_pkg::STATUS_W-1:0]  status,
	output logic [sqd_pkg::TICKET_W-1:0]  ticket,
	output logic [sqd_pkg::SEL_W-1:0]     queue_index,
	output logic [sqd_pkg::LEN_W-1:0]     queue_length
);

	localparam int CW      = $clog2(QUEUE_DEPTH + 1);
	localparam int SW      = $clog2(QUEUE_DEPTH);
	localparam int QW      = $clog2(NUM_QUEUES);
	localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW      = $clog2(ENTRIES);

	// Queue state
	logic [sqd_pkg::TICKET_W-1:0] ticket_counter_q;
	logic [SW-1:0]                head_q  [NUM_QUEUES];
	logic [CW-1:0]                count_q [NUM_QUEUES];
	logic                         out_valid_q;

	// Result stage
	logic [sqd_pkg::STATUS_W-1:0] status_s1;
	logic [sqd_pkg::TICKET_W-1:0] tkt_s1;
	logic [sqd_pkg::SEL_W-1:0]    qidx_s1;
	logic [sqd_pkg::LEN_W-1:0]    qlen_s1;

	logic                         accept;
	logic                         is_take;
	logic [QW-1:0]                best;
	logic [CW-1:0]                cnt_best;
	logic                         take_full;
	logic [sqd_pkg::TICKET_W-1:0] next_ticket;
	logic [SW:0]                  tail_sum;
	logic [SW-1:0]                tail;
	logic                         sel_ok;
	logic [QW-1:0]                selq;
	logic [SW-1:0]                head_sel;
	logic [SW-1:0]                head_next;
	logic [CW-1:0]                cnt_sel;
	logic                         sel_empty;
	logic                         mem_we;
	logic                         mem_re;
	logic [AW-1:0]                mem_waddr;
	logic [AW-1:0]                mem_raddr;
	logic [sqd_pkg::TICKET_W-1:0] mem_rdata;
	logic [NUM_QUEUES-1:0]        full_vec;

	logic [sqd_pkg::STATUS_W-1:0] res_status;
	logic [sqd_pkg::TICKET_W-1:0] res_tkt;
	logic [sqd_pkg::SEL_W-1:0]    res_qidx;
	logic [sqd_pkg::LEN_W-1:0]    res_len;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_take  = (op == sqd_pkg::OP_TAKE);

	// Shortest queue pick
	sqd_select #(
		.NUM_QUEUES (NUM_QUEUES),
		.CW         (CW),
		.QW         (QW)
	) u_select (
		.counts (count_q),
		.best   (best)
	);

	// Take path: counter bump and tail slot of the chosen queue
	always_comb begin
		cnt_best    = count_q[best];
		take_full   = (cnt_best == CW'(QUEUE_DEPTH));
		next_ticket = ticket_counter_q + sqd_pkg::TICKET_W'(1);
		tail_sum    = (SW+1)'(head_q[best]) + (SW+1)'(cnt_best);
		if (tail_sum >= (SW+1)'(QUEUE_DEPTH))
			tail = SW'(tail_sum - (SW+1)'(QUEUE_DEPTH));
		else
			tail = SW'(tail_sum);
	end

	// Serve path: range check, head slot and its successor
	always_comb begin
		sel_ok    = ((sqd_pkg::SEL_W+1)'(queue_select) < (sqd_pkg::SEL_W+1)'(NUM_QUEUES));
		selq      = sel_ok ? queue_select[QW-1:0] : '0;
		head_sel  = head_q[selq];
		cnt_sel   = count_q[selq];
		sel_empty = (cnt_sel == '0);
		if (head_sel == SW'(QUEUE_DEPTH - 1))
			head_next = '0;
		else
			head_next = head_sel + SW'(1);
	end

	// Ticket store access
	assign mem_we    = accept && is_take && !take_full;
	assign mem_re    = accept && !is_take;
	assign mem_waddr = AW'(best) * AW'(QUEUE_DEPTH) + AW'(tail);
	assign mem_raddr = AW'(selq) * AW'(QUEUE_DEPTH) + AW'(head_sel);

	sqd_store #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (next_ticket),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Result fields; a served ticket comes from the store read port
	always_comb begin
		if (is_take) begin
			res_qidx = sqd_pkg::SEL_W'(best);
			if (take_full) begin
				res_status = sqd_pkg::ST_FULL;
				res_tkt    = '0;
				res_len    = sqd_pkg::LEN_W'(QUEUE_DEPTH);
			end else begin
				res_status = sqd_pkg::ST_ASSIGNED;
				res_tkt    = next_ticket;
				res_len    = sqd_pkg::LEN_W'(cnt_best) + sqd_pkg::LEN_W'(1);
			end
		end else begin
			res_qidx = queue_select;
			res_tkt  = '0;
			if (!sel_ok) begin
				res_status = sqd_pkg::ST_INVALID;
				res_len    = '0;
			end else if (sel_empty) begin
				res_status = sqd_pkg::ST_EMPTY;
				res_len    = '0;
			end else begin
				res_status = sqd_pkg::ST_SERVED;
				res_len    = sqd_pkg::LEN_W'(cnt_sel - CW'(1));
			end
		end
	end

	// Queue state update and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticket_counter_q <= '0;
			out_valid_q      <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				if (is_take) begin
					ticket_counter_q <= next_ticket;
					if (!take_full)
						count_q[best] <= cnt_best + CW'(1);
				end else if (sel_ok && !sel_empty) begin
					head_q[selq]  <= head_next;
					count_q[selq] <= cnt_sel - CW'(1);
				end
			end
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= res_status;
			tkt_s1    <= res_tkt;
			qidx_s1   <= res_qidx;
			qlen_s1   <= res_len;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_s1;
	assign ticket       = (status_s1 == sqd_pkg::ST_SERVED) ? mem_rdata : tkt_s1;
	assign queue_index  = qidx_s1;
	assign queue_length = qlen_s1;

	// Per-queue full flags
	always_comb begin
		for (int i = 0; i < NUM_QUEUES; i++)
			full_vec[i] = (count_q[i] == CW'(QUEUE_DEPTH));
	end

	// A transfer always leaves a result waiting
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("no result after request transfer");

	// Counter moves by one on a take and holds otherwise
	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_take) |=> (ticket_counter_q == $past(ticket_counter_q) + 16'd1))
		else $error("ticket counter did not advance on take");

	a_counter_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && is_take) |=> $stable(ticket_counter_q))
		else $error("ticket counter moved without a take");

	// The shortest queue is only full when every queue is full
	a_full_all: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_take && take_full) |-> (&full_vec))
		else $error("full reported while a queue has room");

	// No queue ever holds more than its depth
	for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_bound
		a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			count_q[g] <= CW'(QUEUE_DEPTH))
			else $error("queue entry count beyond depth");
	end

endmodule
